/* sv/arlc_pkg.sv */
// Shared types and constants for the AT response line classifier.
// Used by arlc_cfg, arlc_track, arlc_chk and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arlc_pkg;

  // Default sizes
  localparam int LINE_MAX_DEF   = 256;
  localparam int PREFIX_MAX_DEF = 8;

  // Register port geometry: 64-bit registers at 8-byte spacing
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  // Register indexes
  typedef enum logic [1:0] {
    REG_PREFIX   = 2'd0,
    REG_PLEN     = 2'd1,
    REG_CMD      = 2'd2,
    REG_CAPACITY = 2'd3
  } reg_idx_t;

  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  // Line classes
  typedef enum logic [2:0] {
    CLS_IGNORED     = 3'd0,
    CLS_RESPONSE    = 3'd1,
    CLS_OK          = 3'd2,
    CLS_ERROR       = 3'd3,
    CLS_UNSOLICITED = 3'd4
  } cls_t;

  // Characters
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  localparam logic [7:0] OK_TEXT    [2] = '{8'h4F, 8'h4B};
  localparam logic [7:0] ERROR_TEXT [5] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

  // Configuration as seen by the line tracker
  typedef struct packed {
    logic [63:0] expected_prefix;
    logic [3:0]  prefix_length;
    logic        command_active;
    logic [8:0]  line_capacity;
  } cfg_t;

  // One finished-line result
  typedef struct packed {
    logic       valid;
    cls_t       cls;
    logic [3:0] offset;
    logic [7:0] length;
  } res_t;

endpackage

`default_nettype wire

/* sv/at_response_line_classifier.sv */
// AT response line classifier: the rx byte input register, line tracker and
// line word output register. Depends on arlc_pkg, arlc_cfg and arlc_track.
//
// Usage:
//   Input channel rx_valid / rx_stall carries one received byte per word.
//   Output channel line_valid / line_stall carries one word per finished
//   non-empty line: line_class, param_offset and line_length.
//   Registers are written over the APB-style port at 8-byte spacing
//   (prefix, prefix length, command active, line capacity) while idle.
// Dataflow and throughput:
//   A taken byte is held in the input register, is processed by the line
//   tracker and its line word (if any) is loaded into the output register,
//   from where it can be taken. While line_stall is low one byte per cycle
//   is sustained; the line state is updated by one pass of shallow logic.
// Reset:
//   Synchronous rst empties both registers, restarts the line state and
//   returns the registers to their reset values (capacity 256).
// Stall:
//   A stalled line word holds. One more byte is still taken into the input
//   register behind it; rx_stall rises once that register is also full.
`timescale 1ns / 1ps
`default_nettype none

module at_response_line_classifier #(
  parameter int LINE_MAX   = arlc_pkg::LINE_MAX_DEF,
  parameter int PREFIX_MAX = arlc_pkg::PREFIX_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [arlc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [arlc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [arlc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  // byte input
  input  wire logic                             rx_valid,
  output logic                                  rx_stall,
  input  wire logic [7:0]                       rx_byte,
  // line word output
  output logic                                  line_valid,
  input  wire logic                             line_stall,
  output logic      [2:0]                       line_class,
  output logic      [3:0]                       param_offset,
  output logic      [7:0]                       line_length
);

  arlc_pkg::cfg_t cfg;
  arlc_pkg::res_t res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  logic       rx_take;

  arlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the output register can load when empty or being taken
  assign advance  = !line_valid || !line_stall;
  assign step     = in_valid && advance;
  assign rx_stall = in_valid && !advance;
  assign rx_take  = rx_valid && !rx_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      in_byte <= rx_byte;
    end
  end

  arlc_track #(
    .LINE_MAX   (LINE_MAX),
    .PREFIX_MAX (PREFIX_MAX)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (advance) begin
      line_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      line_class   <= res.cls;
      param_offset <= res.offset;
      line_length  <= res.length;
    end
  end

endmodule

`default_nettype wire

/* sv/arlc_cfg.sv */
// Configuration registers behind the APB-style port.
// Depends on arlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arlc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [arlc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [arlc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [arlc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output arlc_pkg::cfg_t                        cfg
);

  arlc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = arlc_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_prefix <= '0;
      cfg.prefix_length   <= '0;
      cfg.command_active  <= 1'b0;
      cfg.line_capacity   <= arlc_pkg::CAPACITY_RESET;
    end else if (wr_en) begin
      case (idx)
        arlc_pkg::REG_PREFIX:   cfg.expected_prefix <= pwdata;
        arlc_pkg::REG_PLEN:     cfg.prefix_length   <= pwdata[3:0];
        arlc_pkg::REG_CMD:      cfg.command_active  <= pwdata[0];
        arlc_pkg::REG_CAPACITY: cfg.line_capacity   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      arlc_pkg::REG_PREFIX:   prdata = cfg.expected_prefix;
      arlc_pkg::REG_PLEN:     prdata = {60'd0, cfg.prefix_length};
      arlc_pkg::REG_CMD:      prdata = {63'd0, cfg.command_active};
      arlc_pkg::REG_CAPACITY: prdata = {55'd0, cfg.line_capacity};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/arlc_track.sv */
// Per-line match tracking and classification of a finished line.
// Depends on arlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arlc_track #(
  parameter int LINE_MAX   = arlc_pkg::LINE_MAX_DEF,
  parameter int PREFIX_MAX = arlc_pkg::PREFIX_MAX_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     rx_byte,
  input  wire arlc_pkg::cfg_t cfg,
  output arlc_pkg::res_t      res
);

  localparam int CNT_W = $clog2(LINE_MAX);
  localparam int CAP_W = $clog2(LINE_MAX + 1);
  localparam int CMP_W = (CAP_W > 9) ? CAP_W : 9;

  // line state
  logic [CNT_W-1:0] char_count, char_count_next;
  logic             prefix_ok,  prefix_ok_next;
  logic             ok_ok,      ok_ok_next;
  logic             err_ok,     err_ok_next;
  logic             first_ps,   first_ps_next;

  logic             is_end, is_print;
  logic [CMP_W-1:0] pos_x, count_inc, cap_x, cap_eff;
  logic [3:0]       plen_eff;
  logic [2:0]       pidx, eidx;
  logic [7:0]       prefix_char;

  assign is_end   = (rx_byte == arlc_pkg::CHAR_CR) || (rx_byte == arlc_pkg::CHAR_LF);
  assign is_print = (rx_byte >= arlc_pkg::PRINT_LO) && (rx_byte <= arlc_pkg::PRINT_HI);

  assign pos_x     = CMP_W'(char_count);
  assign count_inc = pos_x + CMP_W'(1);
  assign cap_x     = CMP_W'(cfg.line_capacity);

  // effective prefix length and capacity
  assign plen_eff = (cfg.prefix_length > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX)
                                                         : cfg.prefix_length;
  always_comb begin
    if (cap_x == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_x > CMP_W'(LINE_MAX)) begin
      cap_eff = CMP_W'(LINE_MAX);
    end else begin
      cap_eff = cap_x;
    end
  end

  // characters to compare at this position
  assign pidx        = 3'(char_count);
  assign eidx        = (pos_x < CMP_W'(5)) ? 3'(char_count) : 3'd0;
  assign prefix_char = cfg.expected_prefix[pidx*8 +: 8];

  // next line state and end-of-line result
  always_comb begin
    char_count_next = char_count;
    prefix_ok_next  = prefix_ok;
    ok_ok_next      = ok_ok;
    err_ok_next     = err_ok;
    first_ps_next   = first_ps;
    res.valid       = 1'b0;
    res.cls         = arlc_pkg::CLS_IGNORED;
    res.offset      = 4'd0;
    res.length      = 8'(char_count);

    if (step && is_end) begin
      res.valid = (char_count != '0);
      if (cfg.command_active) begin
        if ((plen_eff != 4'd0) && prefix_ok && (pos_x >= CMP_W'(plen_eff))) begin
          res.cls    = arlc_pkg::CLS_RESPONSE;
          res.offset = plen_eff + 4'd1;
        end else if (ok_ok && (pos_x == CMP_W'(2))) begin
          res.cls = arlc_pkg::CLS_OK;
        end else if (err_ok && (pos_x == CMP_W'(5))) begin
          res.cls = arlc_pkg::CLS_ERROR;
        end else if (!first_ps) begin
          res.cls = arlc_pkg::CLS_RESPONSE;
        end
      end
      if ((res.cls == arlc_pkg::CLS_IGNORED) && first_ps) begin
        res.cls = arlc_pkg::CLS_UNSOLICITED;
      end
      char_count_next = '0;
      prefix_ok_next  = 1'b1;
      ok_ok_next      = 1'b1;
      err_ok_next     = 1'b1;
      first_ps_next   = 1'b0;
    end else if (step && is_print) begin
      if ((pos_x < CMP_W'(plen_eff)) && (prefix_char != rx_byte)) begin
        prefix_ok_next = 1'b0;
      end
      if ((pos_x >= CMP_W'(2)) || (arlc_pkg::OK_TEXT[char_count[0]] != rx_byte)) begin
        ok_ok_next = 1'b0;
      end
      if ((pos_x >= CMP_W'(5)) || (arlc_pkg::ERROR_TEXT[eidx] != rx_byte)) begin
        err_ok_next = 1'b0;
      end
      if (char_count == '0) begin
        first_ps_next = (rx_byte == arlc_pkg::CHAR_PLUS) ||
                        (rx_byte == arlc_pkg::CHAR_STAR);
      end
      char_count_next = CNT_W'(count_inc);
      // capacity reached: the line restarts
      if (count_inc >= cap_eff) begin
        char_count_next = '0;
        prefix_ok_next  = 1'b1;
        ok_ok_next      = 1'b1;
        err_ok_next     = 1'b1;
        first_ps_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      prefix_ok  <= 1'b1;
      ok_ok      <= 1'b1;
      err_ok     <= 1'b1;
      first_ps   <= 1'b0;
    end else begin
      char_count <= char_count_next;
      prefix_ok  <= prefix_ok_next;
      ok_ok      <= ok_ok_next;
      err_ok     <= err_ok_next;
      first_ps   <= first_ps_next;
    end
  end

endmodule

`default_nettype wire

/* sv/arlc_chk.sv */
// Port-level checks for the AT response line classifier, bound to the top.
// Depends on arlc_pkg and at_response_line_classifier.
`timescale 1ns / 1ps
`default_nettype none

module arlc_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       line_valid,
  input wire logic       line_stall,
  input wire logic [2:0] line_class,
  input wire logic [3:0] param_offset,
  input wire logic [7:0] line_length
);

  // a stalled line word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    line_valid && line_stall |=> line_valid && $stable(line_class) &&
      $stable(param_offset) && $stable(line_length))
    else $error("stalled line word changed");

  // no word right after reset
  a_reset: assert property (@(posedge clk) rst |=> !line_valid)
    else $error("line word after reset");

  // only a response carries a parameter offset
  a_offset: assert property (@(posedge clk) disable iff (rst)
    line_valid && (line_class != 3'(arlc_pkg::CLS_RESPONSE)) |-> param_offset == 4'd0)
    else $error("offset on non-response line");

  // final status lines have their exact lengths
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    line_valid && (line_class == 3'(arlc_pkg::CLS_OK)) |-> line_length == 8'd2)
    else $error("OK line with wrong length");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    line_valid && (line_class == 3'(arlc_pkg::CLS_ERROR)) |-> line_length == 8'd5)
    else $error("ERROR line with wrong length");

endmodule

bind at_response_line_classifier arlc_chk u_chk (.*);

`default_nettype wire
